/* hw/rtl/subtitle_cue_line_parser_unit_defines.svh */
// ----------------------------------------------------------------------------
// Subtitle cue line parser assertion macros
// Shared property templates for the checker of the cue line parser.
// ----------------------------------------------------------------------------
`ifndef SUBTITLE_CUE_LINE_PARSER_UNIT_DEFINES_SVH
`define SUBTITLE_CUE_LINE_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCLP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCLP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sclp_pkg.sv */
// ----------------------------------------------------------------------------
// Subtitle cue line parser package
// Shared types, character codes and result layout of the cue line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sclp_pkg;

    // Result kinds, carried on the result channel's tuser.
    typedef enum logic [1:0] {
        KIND_HEAD = 2'd0,
        KIND_TEXT = 2'd1,
        KIND_END  = 2'd2,
        KIND_REJ  = 2'd3
    } kind_t;

    // Reject causes.
    typedef enum logic [1:0] {
        RSN_LINE  = 2'd0,
        RSN_START = 2'd1,
        RSN_END   = 2'd2
    } reason_t;

    // What one input byte asks the expander to send.
    typedef enum logic [1:0] {
        OP_REJ       = 2'd0,
        OP_HEAD_TEXT = 2'd1,
        OP_CR_TEXT   = 2'd2,
        OP_END       = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        reason_t    rsn;
        logic [7:0] text;
        logic [3:0] cr_cnt;
    } desc_t;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_CLOSE = 8'h7D;

    localparam logic [3:0] CR_MAX = 4'd15;

    // Milliseconds-per-frame register, unsigned Q10.16.
    localparam int          MPF_W     = 26;
    localparam logic [25:0] MPF_RESET = 26'd2621440;
    localparam int          Q_FRAC    = 16;
    localparam int          MS_W      = 32;

    // Result tdata layout, lowest bit first.
    localparam int TD_START_LSB = 0;
    localparam int TD_END_LSB   = 32;
    localparam int TD_TEXT_LSB  = 64;
    localparam int TD_RSN_LSB   = 72;
    localparam int TD_PAD_W     = 6;
    localparam int M_TDATA_W    = 80;
    localparam int S_TDATA_W    = 8;

    // Configuration port.
    localparam int         APB_DATA_W  = 32;
    localparam int         PADDR_W     = 3;
    localparam logic [0:0] REG_MPF_IDX = 1'b0;

endpackage

/* hw/rtl/subtitle_cue_line_parser_unit.sv */
// ----------------------------------------------------------------------------
// Subtitle cue line parser: each request passes the parse, scale and expand registers.
// Throughput: one byte per cycle unless backed up; multi-result bytes hold the expander.
// Reset (aresetn low, synchronous) empties all stages and restores 40 ms per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block parses a frame-numbered subtitle file one byte at a time. Each
// line reads {start}{end}text. A good line produces a cue header carrying the
// start and end times in milliseconds, then its text bytes, then a cue end.
// A malformed line produces a single reject result with a reason code.
//
// Datapath, one register between each part:
//   parse   - line state machine. Every accepted byte updates the line state
//             and, if it causes any result, leaves one request in the parse
//             register. Bytes that cause nothing do not occupy the pipeline.
//   scale   - both frame numbers are multiplied by the milliseconds-per-frame
//             register into full-width products.
//   expand  - a request is unrolled into one to sixteen results (a reject, a
//             cue end, a header and a text byte, or held-back CRs followed by
//             a text byte), one per cycle into the output register while it has room.
// The stages pass a request on as soon as the stage downstream has room, so
// the parser keeps taking bytes while any request register ahead of it is
// free. The input stalls only when a multi-result request being unrolled or
// a result held in the output register has backed up every register between
// the parser and the output.

module subtitle_cue_line_parser_unit #(
    parameter int FRAME_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input byte stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sclp_pkg::S_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                 s_tuser,   // [0] end_of_file
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sclp_pkg::M_TDATA_W-1:0]       m_tdata,   // [31:0] start_ms,
                                                            // [63:32] end_ms,
                                                            // [71:64] text_byte,
                                                            // [73:72] reason,
                                                            // [79:74] zero
    output logic [1:0]                           m_tuser,   // [1:0] kind
    output logic                                 m_tlast,   // last result of a byte
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sclp_pkg::PADDR_W-1:0]         paddr,
    input  logic [sclp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sclp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import sclp_pkg::*;

    localparam int PW = FRAME_BITS + MPF_W;

    // Milliseconds per frame, unsigned Q10.16. Software must write it only while the
    // stream is idle (the block does not enforce it); the scale stage has no hold logic.
    logic [MPF_W-1:0] mpf_reg;
    logic             mpf_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign mpf_sel   = (paddr[PADDR_W-1:2] == REG_MPF_IDX);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpf_reg <= MPF_RESET;
        end else if (cfg_write && mpf_sel) begin
            mpf_reg <= pwdata[MPF_W-1:0];
        end
    end

    assign prdata = mpf_sel ? {{(APB_DATA_W-MPF_W){1'b0}}, mpf_reg} : '0;

    // Parse stage to scale stage.
    logic                  p_valid, p_ready;
    desc_t                 p_desc;
    logic [FRAME_BITS-1:0] p_start_frame, p_end_frame;

    // Scale stage to expander.
    logic                  x_valid, x_ready;
    desc_t                 x_desc;
    logic [PW-1:0]         x_start_prod, x_end_prod;

    kind_t                 out_kind;

    sclp_parse #(
        .FRAME_BITS      (FRAME_BITS)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_byte         (s_tdata),
        .in_eof          (s_tuser),
        .out_valid       (p_valid),
        .out_ready       (p_ready),
        .out_desc        (p_desc),
        .out_start_frame (p_start_frame),
        .out_end_frame   (p_end_frame)
    );

    sclp_mul #(
        .FRAME_BITS      (FRAME_BITS)
    ) u_mul (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (p_valid),
        .in_ready        (p_ready),
        .in_desc         (p_desc),
        .in_start_frame  (p_start_frame),
        .in_end_frame    (p_end_frame),
        .ms_per_frame    (mpf_reg),
        .out_valid       (x_valid),
        .out_ready       (x_ready),
        .out_desc        (x_desc),
        .out_start_prod  (x_start_prod),
        .out_end_prod    (x_end_prod)
    );

    sclp_emit #(
        .FRAME_BITS      (FRAME_BITS)
    ) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (x_valid),
        .in_ready        (x_ready),
        .in_desc         (x_desc),
        .in_start_prod   (x_start_prod),
        .in_end_prod     (x_end_prod),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_kind        (out_kind),
        .out_data        (m_tdata),
        .out_last        (m_tlast)
    );

    assign m_tuser = out_kind;

endmodule

/* hw/rtl/sclp_parse.sv */
// ----------------------------------------------------------------------------
// Cue line parser front end
// Line state machine; turns each accepted byte into at most one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sclp_parse #(
    parameter int FRAME_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_eof,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sclp_pkg::desc_t       out_desc,
    output logic [FRAME_BITS-1:0] out_start_frame,
    output logic [FRAME_BITS-1:0] out_end_frame
);
    import sclp_pkg::*;

    typedef enum logic [9:0] {
        PH_LINE       = 10'b00_0000_0001,
        PH_OPEN       = 10'b00_0000_0010,
        PH_SDIG       = 10'b00_0000_0100,
        PH_SCLOSE     = 10'b00_0000_1000,
        PH_EDIG       = 10'b00_0001_0000,
        PH_EDIG_OVF   = 10'b00_0010_0000,
        PH_ECLOSE     = 10'b00_0100_0000,
        PH_ECLOSE_OVF = 10'b00_1000_0000,
        PH_TEXT       = 10'b01_0000_0000,
        PH_SKIP       = 10'b10_0000_0000
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [FRAME_BITS-1:0] start_frame_reg, start_frame_next;
    logic [FRAME_BITS-1:0] end_frame_reg, end_frame_next;
    logic                  start_ovf_reg, start_ovf_next;
    logic [3:0]            cr_cnt_reg, cr_cnt_next;

    logic                  p_valid_reg;
    desc_t                 p_desc_reg;
    logic [FRAME_BITS-1:0] p_sf_reg;
    logic [FRAME_BITS-1:0] p_ef_reg;

    logic                  accept;
    logic                  emit;
    desc_t                 desc_next;
    logic                  is_dig;
    logic [3:0]            digit;
    logic [7:0]            text_map;
    logic [FRAME_BITS+3:0] s_ext, s_x10;
    logic [FRAME_BITS+3:0] e_ext, e_x10;
    logic                  s_ovf, e_ovf;

    assign in_ready = !p_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_dig   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = in_byte[3:0];
    assign text_map = (in_byte == CH_BAR) ? CH_LF : in_byte;

    // Decimal accumulate: value * 10 + digit, overflow past FRAME_BITS bits.
    assign s_ext = {4'b0000, start_frame_reg};
    assign s_x10 = (s_ext << 3) + (s_ext << 1) + {{FRAME_BITS{1'b0}}, digit};
    assign s_ovf = |s_x10[FRAME_BITS+3:FRAME_BITS];
    assign e_ext = {4'b0000, end_frame_reg};
    assign e_x10 = (e_ext << 3) + (e_ext << 1) + {{FRAME_BITS{1'b0}}, digit};
    assign e_ovf = |e_x10[FRAME_BITS+3:FRAME_BITS];

    always_comb begin
        phase_next       = phase_reg;
        start_frame_next = start_frame_reg;
        end_frame_next   = end_frame_reg;
        start_ovf_next   = start_ovf_reg;
        cr_cnt_next      = cr_cnt_reg;
        emit             = 1'b0;
        desc_next        = '{op: OP_REJ, rsn: RSN_LINE, text: 8'h00, cr_cnt: 4'd0};

        if (in_eof || in_byte == CH_LF) begin
            priority if (phase_reg == PH_TEXT) begin
                emit         = 1'b1;
                desc_next.op = OP_END;
            end else if (phase_reg == PH_ECLOSE || phase_reg == PH_ECLOSE_OVF) begin
                emit = in_eof;
            end else if (phase_reg != PH_LINE && phase_reg != PH_SKIP) begin
                emit = 1'b1;
            end else begin
                emit = 1'b0;
            end
            cr_cnt_next = 4'd0;
            phase_next  = PH_LINE;
        end else begin
            unique case (phase_reg)
                PH_LINE: begin
                    start_frame_next = '0;
                    end_frame_next   = '0;
                    start_ovf_next   = 1'b0;
                    cr_cnt_next      = 4'd0;
                    if (in_byte == CH_NUL || in_byte == CH_CR) begin
                        phase_next = PH_SKIP;
                    end else if (in_byte == CH_OPEN) begin
                        phase_next = PH_OPEN;
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_OPEN: begin
                    if (is_dig) begin
                        start_frame_next = FRAME_BITS'(digit);
                        phase_next       = PH_SDIG;
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SDIG: begin
                    if (is_dig) begin
                        if (!start_ovf_reg) begin
                            if (s_ovf) begin
                                start_ovf_next = 1'b1;
                            end else begin
                                start_frame_next = s_x10[FRAME_BITS-1:0];
                            end
                        end
                    end else if (in_byte == CH_CLOSE) begin
                        phase_next = PH_SCLOSE;
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SCLOSE: begin
                    if (in_byte == CH_OPEN && !start_ovf_reg) begin
                        end_frame_next = '0;
                        phase_next     = PH_EDIG;
                    end else begin
                        emit          = 1'b1;
                        desc_next.rsn = (in_byte == CH_OPEN) ? RSN_START : RSN_LINE;
                        phase_next    = PH_SKIP;
                    end
                end
                PH_EDIG, PH_EDIG_OVF: begin
                    if (is_dig) begin
                        if (phase_reg == PH_EDIG) begin
                            if (e_ovf) begin
                                phase_next = PH_EDIG_OVF;
                            end else begin
                                end_frame_next = e_x10[FRAME_BITS-1:0];
                            end
                        end
                    end else if (in_byte == CH_CLOSE) begin
                        phase_next = (phase_reg == PH_EDIG) ? PH_ECLOSE : PH_ECLOSE_OVF;
                    end else begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_ECLOSE, PH_ECLOSE_OVF: begin
                    if (in_byte == CH_NUL) begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end else if (in_byte == CH_CR) begin
                        phase_next = PH_SKIP;
                    end else if (phase_reg == PH_ECLOSE_OVF) begin
                        emit          = 1'b1;
                        desc_next.rsn = RSN_END;
                        phase_next    = PH_SKIP;
                    end else begin
                        emit           = 1'b1;
                        desc_next.op   = OP_HEAD_TEXT;
                        desc_next.text = text_map;
                        cr_cnt_next    = 4'd0;
                        phase_next     = PH_TEXT;
                    end
                end
                PH_TEXT: begin
                    if (in_byte == CH_CR) begin
                        if (cr_cnt_reg < CR_MAX) begin
                            cr_cnt_next = cr_cnt_reg + 4'd1;
                        end
                    end else if (in_byte == CH_NUL) begin
                        emit         = 1'b1;
                        desc_next.op = OP_END;
                        cr_cnt_next  = 4'd0;
                        phase_next   = PH_SKIP;
                    end else begin
                        emit             = 1'b1;
                        desc_next.op     = OP_CR_TEXT;
                        desc_next.text   = text_map;
                        desc_next.cr_cnt = cr_cnt_reg;
                        cr_cnt_next      = 4'd0;
                    end
                end
                PH_SKIP: begin
                    phase_next = PH_SKIP;
                end
                default: begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_LINE;
            start_frame_reg <= '0;
            end_frame_reg   <= '0;
            start_ovf_reg   <= 1'b0;
            cr_cnt_reg      <= 4'd0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            start_frame_reg <= start_frame_next;
            end_frame_reg   <= end_frame_next;
            start_ovf_reg   <= start_ovf_next;
            cr_cnt_reg      <= cr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (in_ready) begin
            p_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            p_desc_reg <= desc_next;
            p_sf_reg   <= start_frame_reg;
            p_ef_reg   <= end_frame_reg;
        end
    end

    assign out_valid       = p_valid_reg;
    assign out_desc        = p_desc_reg;
    assign out_start_frame = p_sf_reg;
    assign out_end_frame   = p_ef_reg;

endmodule

/* hw/rtl/sclp_mul.sv */
// ----------------------------------------------------------------------------
// Cue line parser frame scaler
// Multiplies both frame numbers by the milliseconds-per-frame register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sclp_mul #(
    parameter int FRAME_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sclp_pkg::desc_t                      in_desc,
    input  logic [FRAME_BITS-1:0]                in_start_frame,
    input  logic [FRAME_BITS-1:0]                in_end_frame,
    input  logic [sclp_pkg::MPF_W-1:0]           ms_per_frame,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sclp_pkg::desc_t                      out_desc,
    output logic [FRAME_BITS+sclp_pkg::MPF_W-1:0] out_start_prod,
    output logic [FRAME_BITS+sclp_pkg::MPF_W-1:0] out_end_prod
);
    import sclp_pkg::*;

    localparam int PW = FRAME_BITS + MPF_W;

    logic          m_valid_reg;
    desc_t         m_desc_reg;
    logic [PW-1:0] m_sp_reg, m_sp_next;
    logic [PW-1:0] m_ep_reg, m_ep_next;

    assign in_ready = !m_valid_reg || out_ready;

    assign m_sp_next = {{MPF_W{1'b0}}, in_start_frame} * {{FRAME_BITS{1'b0}}, ms_per_frame};
    assign m_ep_next = {{MPF_W{1'b0}}, in_end_frame} * {{FRAME_BITS{1'b0}}, ms_per_frame};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            m_desc_reg <= in_desc;
            m_sp_reg   <= m_sp_next;
            m_ep_reg   <= m_ep_next;
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_desc       = m_desc_reg;
    assign out_start_prod = m_sp_reg;
    assign out_end_prod   = m_ep_reg;

endmodule

/* hw/rtl/sclp_emit.sv */
// ----------------------------------------------------------------------------
// Cue line parser result expander
// Unrolls each request into its results and holds them in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sclp_emit #(
    parameter int FRAME_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  sclp_pkg::desc_t                       in_desc,
    input  logic [FRAME_BITS+sclp_pkg::MPF_W-1:0] in_start_prod,
    input  logic [FRAME_BITS+sclp_pkg::MPF_W-1:0] in_end_prod,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output sclp_pkg::kind_t                       out_kind,
    output logic [sclp_pkg::M_TDATA_W-1:0]        out_data,
    output logic                                  out_last
);
    import sclp_pkg::*;

    localparam int PW = FRAME_BITS + MPF_W;

    logic                 em_valid_reg;
    desc_t                em_desc_reg;
    logic [PW-1:0]        em_sp_reg;
    logic [PW-1:0]        em_ep_reg;
    logic [3:0]           em_idx_reg;

    logic                 o_valid_reg;
    kind_t                o_kind_reg;
    logic [M_TDATA_W-1:0] o_data_reg;
    logic                 o_last_reg;

    kind_t                res_kind;
    logic [MS_W-1:0]      res_start, res_end;
    logic [7:0]           res_text;
    logic [1:0]           res_rsn;
    logic                 res_last;
    logic [M_TDATA_W-1:0] res_data;
    logic                 out_load;
    logic                 em_pop;

    // Drop the fraction and saturate at the top of the 32-bit range.
    function automatic logic [MS_W-1:0] to_ms(input logic [PW-1:0] prod);
        logic [PW+MS_W-1:0] ext;
        ext = {{MS_W{1'b0}}, prod};
        if (|ext[PW+MS_W-1:Q_FRAC+MS_W]) begin
            return '1;
        end
        return ext[Q_FRAC+MS_W-1:Q_FRAC];
    endfunction

    always_comb begin
        res_kind  = KIND_TEXT;
        res_start = '0;
        res_end   = '0;
        res_text  = 8'h00;
        res_rsn   = 2'd0;
        res_last  = 1'b0;
        unique case (em_desc_reg.op)
            OP_REJ: begin
                res_kind = KIND_REJ;
                res_rsn  = em_desc_reg.rsn;
                res_last = 1'b1;
            end
            OP_END: begin
                res_kind = KIND_END;
                res_last = 1'b1;
            end
            OP_HEAD_TEXT: begin
                if (em_idx_reg == 4'd0) begin
                    res_kind  = KIND_HEAD;
                    res_start = to_ms(em_sp_reg);
                    res_end   = to_ms(em_ep_reg);
                end else begin
                    res_text = em_desc_reg.text;
                    res_last = 1'b1;
                end
            end
            OP_CR_TEXT: begin
                if (em_idx_reg < em_desc_reg.cr_cnt) begin
                    res_text = CH_CR;
                end else begin
                    res_text = em_desc_reg.text;
                    res_last = 1'b1;
                end
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    assign res_data = {{TD_PAD_W{1'b0}}, res_rsn, res_text, res_end, res_start};

    assign out_load = em_valid_reg && (!o_valid_reg || out_ready);
    assign em_pop   = out_load && res_last;
    assign in_ready = !em_valid_reg || em_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            em_idx_reg   <= 4'd0;
        end else if (in_ready) begin
            em_valid_reg <= in_valid;
            em_idx_reg   <= 4'd0;
        end else if (out_load) begin
            em_idx_reg <= em_idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            em_desc_reg <= in_desc;
            em_sp_reg   <= in_start_prod;
            em_ep_reg   <= in_end_prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (out_load) begin
            o_valid_reg <= 1'b1;
        end else if (out_ready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_kind_reg <= res_kind;
            o_data_reg <= res_data;
            o_last_reg <= res_last;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_kind  = o_kind_reg;
    assign out_data  = o_data_reg;
    assign out_last  = o_last_reg;

endmodule

/* hw/rtl/sclp_checker.sv */
// ----------------------------------------------------------------------------
// Cue line parser port checker
// Watches the result stream of the cue line parser for ordering slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "subtitle_cue_line_parser_unit_defines.svh"

module sclp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sclp_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            m_tlast
);
    import sclp_pkg::*;

    `SCLP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    `SCLP_ASSERT_NEXT(a_head_then_text, aclk, aresetn, m_tvalid && m_tready && m_tuser == KIND_HEAD, m_tvalid && m_tuser == KIND_TEXT, "cue header not followed by text")

    `SCLP_ASSERT_SAME(a_single_last, aclk, aresetn, m_tvalid && (m_tuser == KIND_REJ || m_tuser == KIND_END), m_tlast, "reject or cue end not marked last")

    `SCLP_ASSERT_SAME(a_reason_only_rej, aclk, aresetn, m_tvalid && m_tuser != KIND_REJ, m_tdata[TD_RSN_LSB +: 2] == 2'd0, "reason set outside a reject")

endmodule

bind subtitle_cue_line_parser_unit sclp_checker u_sclp_checker (.*);

/* dv/subtitle_cue_line_parser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subtitle cue line parser testbench
// Sends whole subtitle lines (good cues, broken lines, overflowing frames,
// noise) byte by byte and checks every result against a line predictor.
// ----------------------------------------------------------------------------

import sclp_pkg::*;

// Scoreboard: predicts the results of each accepted byte and checks the
// result stream against them in order.
class cue_line_scoreboard #(int FRAME_BITS = 24);

    typedef enum int {
        LP_LINE, LP_OPEN, LP_SDIG, LP_SCLOSE, LP_EDIG, LP_EDIG_OVF,
        LP_ECLOSE, LP_ECLOSE_OVF, LP_TEXT, LP_SKIP
    } line_phase_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] start_ms;
        logic [31:0] end_ms;
        logic [7:0]  text;
        reason_t     reason;
        logic        last;
    } cue_result_t;

    cue_result_t  cues_due[$];
    int           errors;
    line_phase_t  phase;
    logic [31:0]  start_frame;
    logic [31:0]  end_frame;
    logic         start_ovf;
    logic [3:0]   cr_held;
    logic [25:0]  ms_per_frame;

    function new();
        errors       = 0;
        phase        = LP_LINE;
        start_frame  = '0;
        end_frame    = '0;
        start_ovf    = 1'b0;
        cr_held      = '0;
        ms_per_frame = MPF_RESET;
    endfunction

    function void set_ms_per_frame(logic [25:0] value);
        ms_per_frame = value;
    endfunction

    function logic [31:0] frame_ms(logic [31:0] frame);
        logic [63:0] prod;
        prod = (64'(frame) * 64'(ms_per_frame)) >> Q_FRAC;
        return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    // One more decimal digit; returns 1 when the frame no longer fits.
    function bit grow_frame(inout logic [31:0] value, input logic [3:0] digit);
        logic [63:0] t;
        t = 64'(value) * 64'd10 + 64'(digit);
        if ((t >> FRAME_BITS) != 0)
            return 1'b1;
        value = t[31:0];
        return 1'b0;
    endfunction

    function void add_cue(kind_t kind, logic [31:0] s_ms, logic [31:0] e_ms,
                          logic [7:0] text, reason_t reason);
        cue_result_t c;
        c.kind     = kind;
        c.start_ms = s_ms;
        c.end_ms   = e_ms;
        c.text     = text;
        c.reason   = reason;
        c.last     = 1'b0;
        cues_due.push_back(c);
    endfunction

    function void reject_line(reason_t reason);
        add_cue(KIND_REJ, '0, '0, '0, reason);
        phase = LP_SKIP;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
        logic        is_digit;
        logic [3:0]  digit;
        logic [7:0]  mapped;
        int          first;
        cue_result_t tail;
        line_phase_t ph;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        digit    = 4'(b - CH_ZERO);
        mapped   = (b == CH_BAR) ? CH_LF : b;
        first    = cues_due.size();
        ph       = phase;
        if (eof || b == CH_LF) begin
            if (ph == LP_TEXT)
                add_cue(KIND_END, '0, '0, '0, RSN_LINE);
            else if (ph == LP_ECLOSE || ph == LP_ECLOSE_OVF) begin
                if (eof)
                    add_cue(KIND_REJ, '0, '0, '0, RSN_LINE);
            end else if (ph != LP_LINE && ph != LP_SKIP)
                add_cue(KIND_REJ, '0, '0, '0, RSN_LINE);
            cr_held = '0;
            phase   = LP_LINE;
        end else begin
            case (ph)
                LP_LINE: begin
                    start_frame = '0;
                    end_frame   = '0;
                    start_ovf   = 1'b0;
                    cr_held     = '0;
                    if (b == CH_NUL || b == CH_CR)
                        phase = LP_SKIP;
                    else if (b == CH_OPEN)
                        phase = LP_OPEN;
                    else
                        reject_line(RSN_LINE);
                end
                LP_OPEN: begin
                    if (is_digit) begin
                        start_frame = 32'(digit);
                        phase       = LP_SDIG;
                    end else
                        reject_line(RSN_LINE);
                end
                LP_SDIG: begin
                    if (is_digit) begin
                        if (!start_ovf && grow_frame(start_frame, digit))
                            start_ovf = 1'b1;
                    end else if (b == CH_CLOSE)
                        phase = LP_SCLOSE;
                    else
                        reject_line(RSN_LINE);
                end
                LP_SCLOSE: begin
                    if (b == CH_OPEN && !start_ovf) begin
                        end_frame = '0;
                        phase     = LP_EDIG;
                    end else
                        reject_line((b == CH_OPEN) ? RSN_START : RSN_LINE);
                end
                LP_EDIG, LP_EDIG_OVF: begin
                    if (is_digit) begin
                        if (ph == LP_EDIG && grow_frame(end_frame, digit))
                            phase = LP_EDIG_OVF;
                    end else if (b == CH_CLOSE)
                        phase = (ph == LP_EDIG) ? LP_ECLOSE : LP_ECLOSE_OVF;
                    else
                        reject_line(RSN_LINE);
                end
                LP_ECLOSE, LP_ECLOSE_OVF: begin
                    if (b == CH_NUL)
                        reject_line(RSN_LINE);
                    else if (b == CH_CR)
                        phase = LP_SKIP;
                    else if (ph == LP_ECLOSE_OVF)
                        reject_line(RSN_END);
                    else begin
                        add_cue(KIND_HEAD, frame_ms(start_frame), frame_ms(end_frame),
                                '0, RSN_LINE);
                        add_cue(KIND_TEXT, '0, '0, mapped, RSN_LINE);
                        cr_held = '0;
                        phase   = LP_TEXT;
                    end
                end
                LP_TEXT: begin
                    if (b == CH_CR) begin
                        if (cr_held < CR_MAX)
                            cr_held++;
                    end else if (b == CH_NUL) begin
                        add_cue(KIND_END, '0, '0, '0, RSN_LINE);
                        cr_held = '0;
                        phase   = LP_SKIP;
                    end else begin
                        repeat (int'(cr_held))
                            add_cue(KIND_TEXT, '0, '0, CH_CR, RSN_LINE);
                        cr_held = '0;
                        add_cue(KIND_TEXT, '0, '0, mapped, RSN_LINE);
                    end
                end
                default: phase = LP_SKIP;
            endcase
        end
        if (cues_due.size() > first) begin
            tail      = cues_due.pop_back();
            tail.last = 1'b1;
            cues_due.push_back(tail);
        end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endfunction

    function void check_result(logic [1:0] kind, logic [M_TDATA_W-1:0] data, logic last);
        cue_result_t want;
        if (cues_due.size() == 0) begin
            errors++;
            $display("%0t: result expected none actual kind %0d data %h", $time, kind, data);
            return;
        end
        want = cues_due.pop_front();
        compare("kind", 32'(want.kind), 32'(kind));
        compare("start_ms", want.start_ms, data[TD_START_LSB +: MS_W]);
        compare("end_ms", want.end_ms, data[TD_END_LSB +: MS_W]);
        compare("text_byte", 32'(want.text), 32'(data[TD_TEXT_LSB +: 8]));
        compare("reason", 32'(want.reason), 32'(data[TD_RSN_LSB +: 2]));
        compare("pad", '0, 32'(data[M_TDATA_W-1 -: TD_PAD_W]));
        compare("last", 32'(want.last), 32'(last));
    endfunction

endclass

module subtitle_cue_line_parser_unit_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int FRAME_BITS   = 24;
    // Roughly 200 random bytes, split over the register settings below; with
    // the directed lines and whole-line rounding this comes to about 230.
    localparam int RANDOM_ITEMS = 200;
    // Cycles with no handshake on any port before the run is declared hung.
    // The slowest legal stretch is a long receiver stall or a settle wait.
    localparam int STALL_LIMIT  = 4000;
    localparam logic [PADDR_W-1:0] MPF_ADDR = {REG_MPF_IDX, 2'b00};

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;   // [7:0] data_byte
    logic                   s_tuser  = 1'b0; // [0] end_of_file
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // [31:0] start_ms, [63:32] end_ms,
                                             // [71:64] text_byte, [73:72] reason
    logic [1:0]             m_tuser;         // [1:0] kind
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    cue_line_scoreboard #(FRAME_BITS) sb;

    // Bytes of the line being built; bit 8 carries the end-of-file flag.
    logic [8:0] line_q[$];
    int         burst_left = 0;
    int         stall_mode = 0;
    int         mode_left  = 0;
    int         quiet_cycles = 0;

    subtitle_cue_line_parser_unit #(.FRAME_BITS(FRAME_BITS)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Receiver back-pressure. The stall pattern switches at random between
    // always ready, mostly ready, mostly stalled and a toggling pattern, so
    // stalls land on every phase of a cue, including the middle of a long CR
    // burst being unrolled.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(4, 80);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Watchdog: any handshake on either stream or the register port counts
    // as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line building. Each function appends bytes to line_q.
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        line_q.push_back({1'b0, b});
    endfunction

    // The byte lane is ignored with end of file, so it carries noise.
    function automatic void push_eof();
        line_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic void push_digits(input int count, input bit lead_nonzero);
        for (int i = 0; i < count; i++)
            push_byte(CH_ZERO + 8'((i == 0 && lead_nonzero) ? $urandom_range(1, 9)
                                                             : $urandom_range(0, 9)));
    endfunction

    // A frame field: mostly short numbers, some long ones, and the values
    // right at and just past the largest frame that fits in FRAME_BITS.
    function automatic void push_frame_field(input bit allow_empty);
        int r;
        r = $urandom_range(0, 99);
        if (allow_empty && r < 12)
            return;
        if (r < 17)
            push_str(r[0] ? "16777215" : "16777216");
        else if (r < 27)
            push_digits($urandom_range(4, 8), 1'b0);
        else
            push_digits($urandom_range(1, 3), 1'b0);
    endfunction

    // Cue text with bars, CR runs in the middle (a few longer than the
    // fifteen the block can hold) and any other byte but NUL, LF and CR.
    function automatic void push_text();
        int len;
        int r;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        push_byte(text_char());
        for (int i = 1; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                push_byte(CH_BAR);
            else if (r < 20)
                repeat (($urandom_range(0, 19) == 0) ? $urandom_range(14, 19)
                                                     : $urandom_range(1, 3))
                    push_byte(CH_CR);
            else
                push_byte(text_char());
        end
    endfunction

    // Line endings: plain newline, trailing CRs, a NUL followed by ignored
    // bytes, or end of file.
    function automatic void end_line();
        int r;
        r = $urandom_range(0, 99);
        if ((r >= 60 && r < 75) || r >= 92)
            repeat ($urandom_range(1, 3)) push_byte(CH_CR);
        if (r >= 75 && r < 85) begin
            push_byte(CH_NUL);
            repeat ($urandom_range(0, 3)) push_byte(text_char());
        end
        if (r >= 85)
            push_eof();
        else
            push_byte(CH_LF);
    endfunction

    function automatic void gen_line();
        int r;
        int cut;
        line_q.delete();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // Blank line, or one led by a CR or a NUL that is skipped.
            if (r >= 3) begin
                push_byte((r < 6) ? CH_CR : CH_NUL);
                repeat ($urandom_range(0, 3)) push_byte(text_char());
            end
            push_byte(CH_LF);
        end else if (r < 16) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
            end_line();
        end else begin
            // Well-formed cue; some force a start or end frame overflow.
            push_byte(CH_OPEN);
            if (r < 24)
                push_digits($urandom_range(9, 10), 1'b1);
            else
                push_frame_field(1'b0);
            push_byte(CH_CLOSE);
            push_byte(CH_OPEN);
            if (r >= 24 && r < 32)
                push_digits($urandom_range(9, 10), 1'b1);
            else
                push_frame_field(1'b1);
            push_byte(CH_CLOSE);
            // Now and then nothing follows the end brace.
            if ($urandom_range(0, 9) != 0)
                push_text();
            end_line();
            // Broken cue: either one byte is replaced by noise or the line is
            // cut short and ended early.
            if (r >= 86) begin
                cut = $urandom_range(0, line_q.size() - 1);
                if ($urandom_range(0, 1) == 0) begin
                    line_q[cut] = {1'b0, 8'($urandom_range(0, 255))};
                end else begin
                    while (line_q.size() > cut)
                        void'(line_q.pop_back());
                    end_line();
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Sends one byte request. The sender works in bursts; between bursts it
    // idles for a random gap, sometimes none and now and then a long one.
    task automatic send_item(input logic [8:0] item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(8, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= item[7:0];
        s_tuser  <= item[8];
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(item[7:0], item[8]);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_item(line_q[i]);
    endtask

    // Waits until every predicted result has arrived, then lets the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.cues_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access cycle meets pready.
    task automatic write_ms_per_frame(input logic [25:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MPF_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_ms_per_frame(value);
    endtask

    task automatic run_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            gen_line();
            send_line();
            sent += line_q.size();
        end
    endtask

    initial begin
        logic [25:0] mpf_plan[4];
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines at the reset rate of 40 ms per frame: a cue with an
        // empty end field, a bar, a CR inside the text and a trailing CR; a
        // line led by a CR; an empty line; a line led by a NUL; a cue with
        // nothing after its end brace; and a 0xFF byte cut off by end of file.
        line_q.delete();
        push_str("{0}{}|");
        push_byte(CH_CR);
        push_str("A");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_LF);
        push_byte(CH_NUL);
        push_byte(CH_LF);
        push_str("{5}{7}");
        push_byte(CH_LF);
        push_byte(8'hFF);
        push_eof();
        send_line();
        settle();

        // Random traffic under several rates: the smallest step, the largest
        // register value (which saturates long cues), any value, and a
        // realistic video rate.
        mpf_plan[0] = 26'd1;
        mpf_plan[1] = 26'h3FF_FFFF;
        mpf_plan[2] = 26'($urandom_range(1, 26'h3FF_FFFF));
        mpf_plan[3] = 26'($urandom_range(2000000, 2800000));
        foreach (mpf_plan[i]) begin
            write_ms_per_frame(mpf_plan[i]);
            run_random(RANDOM_ITEMS / 4);
            settle();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.cues_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
